>>> hw/rtl/rrss_pkg.sv
// shared constants and types for the round-robin slice scheduler
package rrss_pkg;

   localparam int MAX_PROCS    = 16;
   localparam int SLOT_W       = $clog2(MAX_PROCS);
   localparam int COUNT_W      = $clog2(MAX_PROCS + 1);
   localparam int BURST_W      = 16;
   localparam int QUANTUM_W    = 8;
   localparam int PROC_INDEX_W = 4;
   localparam int RSP_DATA_W   = 16;

   localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = QUANTUM_W'(4);

   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_NEXT = 1'b1;

   typedef struct packed {
      logic add;
      logic start;
      logic advance;
      logic grant;
      logic none;
   } rrss_cmd_type;

   typedef struct packed {
      logic hit;
      logic last;
      logic out_free;
   } rrss_status_type;

endpackage

>>> hw/rtl/rrss_ctrl.sv
// control state machine for the round-robin slice scheduler
module rrss_ctrl
   import rrss_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   input  logic            req_tuser,
   output logic            req_tready,
   input  rrss_status_type status,
   output rrss_cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == REQ_ADD) begin
                  cmd.add = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (status.hit) begin
               if (status.out_free) begin
                  cmd.grant = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else if (status.last) begin
               if (status.out_free) begin
                  cmd.none = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.advance = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/rrss_datapath.sv
// process table, cursor, slot walk and result register
module rrss_datapath
   import rrss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [BURST_W-1:0]    req_tdata,
   input  logic                  csr_we,
   input  logic [QUANTUM_W-1:0]  csr_wdata,
   input  rrss_cmd_type          cmd,
   output rrss_status_type       status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   logic [BURST_W-1:0]      burst_ff [MAX_PROCS];
   logic [COUNT_W-1:0]      count_ff;
   logic [SLOT_W-1:0]       cursor_ff;
   logic [SLOT_W-1:0]       idx_ff;
   logic [SLOT_W-1:0]       idx_in;
   logic [COUNT_W-1:0]      steps_ff;
   logic [QUANTUM_W-1:0]    quantum_ff;
   logic                    rsp_valid_ff;
   logic [PROC_INDEX_W-1:0] rsp_index_ff;
   logic [QUANTUM_W-1:0]    rsp_slice_ff;
   logic                    rsp_done_ff;

   logic [BURST_W-1:0]      rem;
   logic [QUANTUM_W-1:0]    q;
   logic [QUANTUM_W-1:0]    slice;
   logic [COUNT_W-1:0]      idx_plus;
   logic [SLOT_W-1:0]       idx_wrap;
   logic [SLOT_W-1:0]       start_slot;
   logic                    table_full;

   assign rem        = burst_ff[idx_ff];
   assign q          = (quantum_ff == '0) ? QUANTUM_W'(1) : quantum_ff;
   assign slice      = (rem < BURST_W'(q)) ? QUANTUM_W'(rem) : q;
   assign idx_plus   = COUNT_W'(idx_ff) + COUNT_W'(1);
   assign idx_wrap   = (idx_plus >= count_ff) ? '0 : idx_plus[SLOT_W-1:0];
   assign start_slot = (COUNT_W'(cursor_ff) < count_ff) ? cursor_ff : '0;
   assign table_full = (count_ff >= COUNT_W'(MAX_PROCS));

   assign status.hit      = (count_ff != '0) && (rem != '0);
   assign status.last     = (count_ff == '0) || ((steps_ff + COUNT_W'(1)) >= count_ff);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.start) begin
         idx_in = start_slot;
      end else if (cmd.advance) begin
         idx_in = idx_wrap;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add && !table_full) begin
         burst_ff[count_ff[SLOT_W-1:0]] <= req_tdata;
      end else if (cmd.grant) begin
         burst_ff[idx_ff] <= rem - BURST_W'(slice);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         idx_ff       <= '0;
         steps_ff     <= '0;
         quantum_ff   <= QUANTUM_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (csr_we) begin
            quantum_ff <= csr_wdata;
         end
         if (cmd.add && !table_full) begin
            count_ff <= count_ff + COUNT_W'(1);
         end
         if (cmd.start) begin
            steps_ff <= '0;
         end else if (cmd.advance) begin
            steps_ff <= steps_ff + COUNT_W'(1);
         end
         if (cmd.grant) begin
            cursor_ff <= idx_wrap;
         end
         if (cmd.grant || cmd.none) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.grant) begin
         rsp_index_ff <= PROC_INDEX_W'(idx_ff);
         rsp_slice_ff <= slice;
         rsp_done_ff  <= 1'b0;
      end else if (cmd.none) begin
         rsp_index_ff <= '0;
         rsp_slice_ff <= '0;
         rsp_done_ff  <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_slice_ff, rsp_index_ff});
   assign rsp_tuser  = rsp_done_ff;

endmodule

>>> hw/rtl/round_robin_slice_scheduler_unit.sv
// round-robin time-slice scheduler top level
// add item: accepted while idle, and the block stays idle for the item after it
// next item: walks the filled slots from the cursor, one table slot per cycle
// the walk sets the rate; it stalls at a hit or last slot until the output is free
// a result waits in the output register while the next item is accepted
// reset: synchronous, empties the table, cursor to 0, quantum to 4, no clearing pass
module round_robin_slice_scheduler_unit
   import rrss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BURST_W-1:0]    req_tdata,   // burst_length
   input  logic                  req_tuser,   // req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // proc_index, slice_len, zero pad
   output logic                  rsp_tuser,   // all_done
   input  logic                  csr_we,
   input  logic [QUANTUM_W-1:0]  csr_wdata
);

   rrss_cmd_type    cmd;
   rrss_status_type status;

   rrss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rrss_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
